FILE: rtl/core/wu_antialiased_line_2bit_defines.svh
// Assertion macros shared by the antialiased line rasteriser modules.
`ifndef WU_ANTIALIASED_LINE_2BIT_DEFINES_SVH
`define WU_ANTIALIASED_LINE_2BIT_DEFINES_SVH

// Check an expression on every clock edge outside reset.
`define WAL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define WAL_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/wal_pkg.sv
// Package: widths, command and status types for the antialiased line rasteriser.
`default_nettype none

package wal_pkg;

  localparam int COORD_BITS     = 8;
  localparam int FRAC_BITS      = 16;
  localparam int LEVEL_BITS     = 2;
  localparam int RUN_BITS       = COORD_BITS + 1;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_BITS   = $clog2(FRAC_BITS + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [FRAC_BITS-1:0]  frac_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [RUN_BITS-1:0]   run_t;

  localparam level_t LEVEL_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_SPAN    = 2'd1,
    CMD_LINE    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    coord_t    px;
    coord_t    py;
    coord_t    fx;
    coord_t    fy;
    coord_t    major;
    coord_t    minor;
    logic      y_major;
    logic      x_neg;
    logic      vert;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/wal_front.sv
// Front end: accept input transactions, order endpoints and classify them into commands.
`default_nettype none

module wal_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  wal_pkg::coord_t    in_start_x,
  input  wal_pkg::coord_t    in_start_y,
  input  wal_pkg::coord_t    in_end_x,
  input  wal_pkg::coord_t    in_end_y,
  output logic               push,
  output wal_pkg::cmd_t      cmd,
  input  wal_pkg::q_status_t q_status
);
  import wal_pkg::*;

  logic   cmd_valid_r, cmd_valid_nxt;
  cmd_t   cmd_r, cmd_nxt, dec;
  logic   accept, swap, x_neg, y_major;
  coord_t x0, y0, x1, y1, dx, dy;

  always_comb begin
    swap    = in_start_y > in_end_y;
    x0      = swap ? in_end_x : in_start_x;
    y0      = swap ? in_end_y : in_start_y;
    x1      = swap ? in_start_x : in_end_x;
    y1      = swap ? in_start_y : in_end_y;
    dy      = y1 - y0;
    x_neg   = x1 < x0;
    dx      = x_neg ? (x0 - x1) : (x1 - x0);
    y_major = dy > dx;

    dec.kind    = in_action ? CMD_ADVANCE :
                  ((dx == '0) || (dy == '0)) ? CMD_SPAN : CMD_LINE;
    dec.px      = ((dx != '0) && (dy == '0) && x_neg) ? x1 : x0;
    dec.py      = y0;
    dec.fx      = x1;
    dec.fy      = y1;
    dec.major   = y_major ? dy : dx;
    dec.minor   = y_major ? dx : dy;
    dec.y_major = y_major;
    dec.x_neg   = x_neg;
    dec.vert    = dx == '0;
  end

  assign in_stall = cmd_valid_r && q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = cmd_valid_r && !q_status.full;
  assign cmd      = cmd_r;

  always_comb begin
    cmd_valid_nxt = accept || (cmd_valid_r && !push);
    cmd_nxt       = accept ? dec : cmd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/wal_fifo.sv
// Command queue between the front end and the back end.
`default_nettype none
`include "wu_antialiased_line_2bit_defines.svh"

module wal_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wal_pkg::cmd_t      din,
  input  logic               pop,
  output wal_pkg::cmd_t      dout,
  output wal_pkg::q_status_t status
);
  import wal_pkg::*;

  cmd_t                      mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                      do_push, do_pop;

  assign status.full  = cnt_r == QUEUE_CNT_BITS'(QUEUE_DEPTH);
  assign status.empty = cnt_r == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign dout         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + QUEUE_PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + QUEUE_PTR_BITS'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QUEUE_CNT_BITS'(1);
      2'b01:   cnt_nxt = cnt_r - QUEUE_CNT_BITS'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `WAL_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue overfilled")
  `WAL_ASSERT_IMPLY(a_no_pop_empty, pop, !status.empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/core/wal_div.sv
// Restoring divider: slope fraction minor * 2^FRAC_BITS / major, one quotient bit a cycle.
`default_nettype none

module wal_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  wal_pkg::coord_t      minor,
  input  wal_pkg::coord_t      major,
  output wal_pkg::div_status_t status,
  output wal_pkg::frac_t       quotient
);
  import wal_pkg::*;

  coord_t                  rem_r, rem_nxt, div_r, div_nxt;
  frac_t                   quo_r, quo_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [COORD_BITS:0]     shifted, diff;
  logic                    ge;

  assign status.busy = cnt_r != '0;
  assign status.done = done_r;
  assign quotient    = quo_r;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, div_r};
    ge       = shifted >= {1'b0, div_r};
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = (minor == major) ? '0 : minor;
      div_nxt = major;
      quo_nxt = '0;
      cnt_nxt = DIV_CNT_BITS'(FRAC_BITS);
    end else if (status.busy) begin
      rem_nxt  = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
      quo_nxt  = {quo_r[FRAC_BITS-2:0], ge};
      cnt_nxt  = cnt_r - DIV_CNT_BITS'(1);
      done_nxt = cnt_r == DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/wal_back.sv
// Back end: line stepping state, slope divider and the registered result stage.
`default_nettype none
`include "wu_antialiased_line_2bit_defines.svh"

module wal_back (
  input  logic               clk,
  input  logic               rst_n,
  input  wal_pkg::cmd_t      q_cmd,
  input  wal_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output wal_pkg::coord_t    out_pixel_x,
  output wal_pkg::coord_t    out_pixel_y,
  output wal_pkg::level_t    out_color_index,
  output wal_pkg::run_t      out_run_length,
  output logic               out_run_vertical,
  output logic               out_last_of_line
);
  import wal_pkg::*;

  typedef enum logic [1:0] {
    ST_READY  = 2'b01,
    ST_DIVIDE = 2'b10
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic        active_r, active_nxt, y_major_r, y_major_nxt, x_neg_r, x_neg_nxt;
  logic        comp_r, comp_nxt;
  frac_t       acc_r, acc_nxt, adj_r, adj_nxt, sum;
  coord_t      cx_r, cx_nxt, cy_r, cy_nxt, steps_r, steps_nxt, fx_r, fx_nxt;
  coord_t      fy_r, fy_nxt, cx_step, nx, ny;
  level_t      lw_r, lw_nxt, nlw;
  logic        carry, load_ok, div_start;
  div_status_t div_status;
  frac_t       quotient;

  logic        out_valid_r, out_valid_nxt, res_valid;
  coord_t      px_r, py_r, res_px, res_py;
  level_t      col_r, res_col;
  run_t        len_r, res_len;
  logic        vert_r, last_r, res_vert, res_last;

  function automatic coord_t x_step(input coord_t x, input logic neg);
    x_step = neg ? (x - COORD_BITS'(1)) : (x + COORD_BITS'(1));
  endfunction

  wal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .minor    (q_cmd.minor),
    .major    (q_cmd.major),
    .status   (div_status),
    .quotient (quotient)
  );

  assign load_ok = !out_valid_r || !out_stall;
  assign pop     = (state_r == ST_READY) && !q_status.empty && load_ok;

  always_comb begin
    sum     = acc_r + adj_r;
    carry   = sum <= acc_r;
    cx_step = x_step(cx_r, x_neg_r);
    nx      = y_major_r ? (carry ? cx_step : cx_r) : cx_step;
    ny      = y_major_r ? (cy_r + COORD_BITS'(1)) :
              (carry ? (cy_r + COORD_BITS'(1)) : cy_r);
    nlw     = sum[FRAC_BITS-1 -: LEVEL_BITS];
  end

  always_comb begin
    state_nxt   = state_r;
    active_nxt  = active_r;
    y_major_nxt = y_major_r;
    x_neg_nxt   = x_neg_r;
    comp_nxt    = comp_r;
    acc_nxt     = acc_r;
    adj_nxt     = adj_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    steps_nxt   = steps_r;
    fx_nxt      = fx_r;
    fy_nxt      = fy_r;
    lw_nxt      = lw_r;
    div_start   = 1'b0;
    res_valid   = 1'b0;
    res_px      = cx_r;
    res_py      = cy_r;
    res_col     = LEVEL_MAX;
    res_len     = RUN_BITS'(1);
    res_vert    = 1'b0;
    res_last    = 1'b0;

    if (pop) begin
      case (q_cmd.kind)
        CMD_SPAN: begin
          active_nxt = 1'b0;
          comp_nxt   = 1'b0;
          x_neg_nxt  = q_cmd.x_neg;
          res_valid  = 1'b1;
          res_px     = q_cmd.px;
          res_py     = q_cmd.py;
          res_len    = RUN_BITS'(q_cmd.major) + RUN_BITS'(1);
          res_vert   = q_cmd.vert;
          res_last   = 1'b1;
        end
        CMD_LINE: begin
          active_nxt  = 1'b1;
          comp_nxt    = 1'b0;
          y_major_nxt = q_cmd.y_major;
          x_neg_nxt   = q_cmd.x_neg;
          acc_nxt     = '0;
          steps_nxt   = q_cmd.major - COORD_BITS'(1);
          cx_nxt      = q_cmd.px;
          cy_nxt      = q_cmd.py;
          fx_nxt      = q_cmd.fx;
          fy_nxt      = q_cmd.fy;
          lw_nxt      = '0;
          div_start   = 1'b1;
          state_nxt   = ST_DIVIDE;
          res_valid   = 1'b1;
          res_px      = q_cmd.px;
          res_py      = q_cmd.py;
        end
        CMD_ADVANCE: begin
          if (active_r) begin
            res_valid = 1'b1;
            if (comp_r) begin
              comp_nxt = 1'b0;
              res_px   = y_major_r ? cx_step : cx_r;
              res_py   = y_major_r ? cy_r : (cy_r + COORD_BITS'(1));
              res_col  = LEVEL_MAX - (lw_r ^ LEVEL_MAX);
            end else if (steps_r != '0) begin
              acc_nxt   = sum;
              cx_nxt    = nx;
              cy_nxt    = ny;
              lw_nxt    = nlw;
              steps_nxt = steps_r - COORD_BITS'(1);
              comp_nxt  = 1'b1;
              res_px    = nx;
              res_py    = ny;
              res_col   = LEVEL_MAX - nlw;
            end else begin
              active_nxt = 1'b0;
              res_px     = fx_r;
              res_py     = fy_r;
              res_last   = 1'b1;
            end
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end

    if ((state_r == ST_DIVIDE) && div_status.done) begin
      adj_nxt   = quotient;
      state_nxt = ST_READY;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      active_r    <= 1'b0;
      y_major_r   <= 1'b0;
      x_neg_r     <= 1'b0;
      comp_r      <= 1'b0;
      acc_r       <= '0;
      adj_r       <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      steps_r     <= '0;
      fx_r        <= '0;
      fy_r        <= '0;
      lw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      y_major_r   <= y_major_nxt;
      x_neg_r     <= x_neg_nxt;
      comp_r      <= comp_nxt;
      acc_r       <= acc_nxt;
      adj_r       <= adj_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      steps_r     <= steps_nxt;
      fx_r        <= fx_nxt;
      fy_r        <= fy_nxt;
      lw_r        <= lw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      px_r   <= res_px;
      py_r   <= res_py;
      col_r  <= res_col;
      len_r  <= res_len;
      vert_r <= res_vert;
      last_r <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = px_r;
  assign out_pixel_y      = py_r;
  assign out_color_index  = col_r;
  assign out_run_length   = len_r;
  assign out_run_vertical = vert_r;
  assign out_last_of_line = last_r;

  `WAL_ASSERT_IMPLY(a_div_active, state_r == ST_DIVIDE, active_r, "dividing with no line")
  `WAL_ASSERT_IMPLY(a_busy_state, div_status.busy, state_r == ST_DIVIDE, "divider runs unowned")
  `WAL_ASSERT_IMPLY(a_load_free, res_valid, load_ok, "result overwrites a held transaction")

endmodule

`default_nettype wire

FILE: rtl/core/wu_antialiased_line_2bit.sv
// Top level of the 2-bit antialiased line rasteriser.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   in_     | input     | in_valid / in_stall   | action, start_x/y, end_x/y
//   out_    | output    | out_valid / out_stall | pixel_x/y, color_index, run_length,
//           |           |                      | run_vertical, last_of_line
//
// Advance transactions and spans sustain one transaction a cycle once the pipeline is full and
// out_stall is low. A sloped line start occupies the back end while the restoring divider forms
// the slope; queued transactions wait behind it.
// From input to result a transaction passes the front register, the queue and the result register.
// Reset is synchronous, active low, and clears all control state; no clearing pass.
// Either side may stall at will; a two-entry queue decouples front and back.
`default_nettype none

module wu_antialiased_line_2bit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_action,
  input  wal_pkg::coord_t in_start_x,
  input  wal_pkg::coord_t in_start_y,
  input  wal_pkg::coord_t in_end_x,
  input  wal_pkg::coord_t in_end_y,
  output logic            out_valid,
  input  logic            out_stall,
  output wal_pkg::coord_t out_pixel_x,
  output wal_pkg::coord_t out_pixel_y,
  output wal_pkg::level_t out_color_index,
  output wal_pkg::run_t   out_run_length,
  output logic            out_run_vertical,
  output logic            out_last_of_line
);
  import wal_pkg::*;

  logic      push, pop;
  cmd_t      front_cmd, q_cmd;
  q_status_t q_status;

  wal_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_action  (in_action),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .push       (push),
    .cmd        (front_cmd),
    .q_status   (q_status)
  );

  wal_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .din    (front_cmd),
    .pop    (pop),
    .dout   (q_cmd),
    .status (q_status)
  );

  wal_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_cmd            (q_cmd),
    .q_status         (q_status),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_color_index  (out_color_index),
    .out_run_length   (out_run_length),
    .out_run_vertical (out_run_vertical),
    .out_last_of_line (out_last_of_line)
  );

endmodule

`default_nettype wire

FILE: bench/tb_wu_antialiased_line_2bit.sv
// Self-checking bench for the 2-bit antialiased line rasteriser, with its own pixel predictor.
module tb_wu_antialiased_line_2bit;
  timeunit 1ns;
  timeprecision 1ps;

  import wal_pkg::*;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef struct {
    coord_t x;
    coord_t y;
    level_t colour;
    run_t   len;
    logic   vert;
    logic   last;
  } pixel_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   in_action = ACT_START;
  coord_t in_start_x = '0;
  coord_t in_start_y = '0;
  coord_t in_end_x = '0;
  coord_t in_end_y = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  level_t out_color_index;
  run_t   out_run_length;
  logic   out_run_vertical;
  logic   out_last_of_line;

  // line tracing state
  bit                  ln_active;
  bit                  ln_ymaj;
  bit                  ln_xneg;
  bit                  ln_comp;
  logic [FRAC_BITS-1:0] ln_acc;
  logic [FRAC_BITS-1:0] ln_adj;
  coord_t              ln_x;
  coord_t              ln_y;
  coord_t              ln_steps;
  coord_t              ln_end_x;
  coord_t              ln_end_y;
  level_t              ln_weight;

  pixel_t pixels_due[$];
  int     mismatches = 0;
  int     send_pct = 0;
  int     stall_pct = 0;
  logic   hold_off = 1'b0;

  wu_antialiased_line_2bit dut (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(255));
  endfunction

  function automatic coord_t step_x(coord_t x);
    return ln_xneg ? coord_t'(x - 1'b1) : coord_t'(x + 1'b1);
  endfunction

  function automatic void push_pixel(coord_t x, coord_t y, level_t c, run_t n, logic v,
                                     logic l);
    pixel_t p;
    p.x = x;
    p.y = y;
    p.colour = c;
    p.len = n;
    p.vert = v;
    p.last = l;
    pixels_due.push_back(p);
  endfunction

  function automatic void rasterise_step(logic act, coord_t sx, coord_t sy, coord_t ex,
                                         coord_t ey);
    coord_t x0, y0, x1, y1, t, dx, dy, major, minor;
    logic [FRAC_BITS-1:0] prev;
    logic [FRAC_BITS+COORD_BITS-1:0] quot;
    level_t w;
    logic carry;
    if (act == ACT_START) begin
      x0 = sx;
      y0 = sy;
      x1 = ex;
      y1 = ey;
      if (y0 > y1) begin
        t = y0; y0 = y1; y1 = t;
        t = x0; x0 = x1; x1 = t;
      end
      dy = y1 - y0;
      ln_xneg = x1 < x0;
      dx = ln_xneg ? coord_t'(x0 - x1) : coord_t'(x1 - x0);
      ln_active = 1'b0;
      ln_comp = 1'b0;
      if (dx == 0) begin
        push_pixel(x0, y0, LEVEL_MAX, run_t'(dy) + 1'b1, 1'b1, 1'b1);
      end else if (dy == 0) begin
        push_pixel(ln_xneg ? x1 : x0, y0, LEVEL_MAX, run_t'(dx) + 1'b1, 1'b0, 1'b1);
      end else begin
        ln_ymaj = dy > dx;
        major = ln_ymaj ? dy : dx;
        minor = ln_ymaj ? dx : dy;
        quot = {minor, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, major};
        ln_adj = quot[FRAC_BITS-1:0];
        ln_acc = '0;
        ln_steps = major - 1'b1;
        ln_x = x0;
        ln_y = y0;
        ln_end_x = x1;
        ln_end_y = y1;
        ln_weight = '0;
        ln_active = 1'b1;
        push_pixel(x0, y0, LEVEL_MAX, run_t'(1), 1'b0, 1'b0);
      end
    end else if (ln_active) begin
      if (ln_comp) begin
        w = ln_weight ^ LEVEL_MAX;
        ln_comp = 1'b0;
        push_pixel(ln_ymaj ? step_x(ln_x) : ln_x, ln_ymaj ? ln_y : coord_t'(ln_y + 1'b1),
                   LEVEL_MAX - w, run_t'(1), 1'b0, 1'b0);
      end else if (ln_steps != 0) begin
        prev = ln_acc;
        ln_acc = ln_acc + ln_adj;
        carry = ln_acc <= prev;
        if (ln_ymaj) begin
          if (carry) ln_x = step_x(ln_x);
          ln_y = ln_y + 1'b1;
        end else begin
          if (carry) ln_y = ln_y + 1'b1;
          ln_x = step_x(ln_x);
        end
        ln_weight = ln_acc[FRAC_BITS-1 -: LEVEL_BITS];
        ln_steps = ln_steps - 1'b1;
        ln_comp = 1'b1;
        push_pixel(ln_x, ln_y, LEVEL_MAX - ln_weight, run_t'(1), 1'b0, 1'b0);
      end else begin
        ln_active = 1'b0;
        push_pixel(ln_end_x, ln_end_y, LEVEL_MAX, run_t'(1), 1'b0, 1'b1);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_pixel();
    pixel_t p;
    if (pixels_due.size() == 0) begin
      $error("unexpected result at (%0d,%0d)", out_pixel_x, out_pixel_y);
      mismatches++;
    end else begin
      p = pixels_due.pop_front();
      check_field("pixel_x", 16'(p.x), 16'(out_pixel_x));
      check_field("pixel_y", 16'(p.y), 16'(out_pixel_y));
      check_field("color_index", 16'(p.colour), 16'(out_color_index));
      check_field("run_length", 16'(p.len), 16'(out_run_length));
      check_field("run_vertical", 16'(p.vert), 16'(out_run_vertical));
      check_field("last_of_line", 16'(p.last), 16'(out_last_of_line));
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_pixel();
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  task automatic set_idling(input int s_pct, input int r_pct);
    send_pct = s_pct;
    stall_pct <= r_pct;
  endtask

  task automatic send_item(input logic act, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rasterise_step(act, sx, sy, ex, ey);
  endtask

  task automatic send_advance();
    send_item(ACT_ADVANCE, any_coord(), any_coord(), any_coord(), any_coord());
  endtask

  task automatic run_line(input coord_t sx, input coord_t sy, input coord_t ex,
                          input coord_t ey);
    send_item(ACT_START, sx, sy, ex, ey);
    while (ln_active) send_advance();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic pick_line(output coord_t sx, output coord_t sy, output coord_t ex,
                           output coord_t ey);
    int mode, wx, wy, bx, by;
    mode = $urandom_range(9);
    wx = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
    wy = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12);
    if (mode == 0) wx = 0;
    else if (mode == 1) wy = 0;
    else if (mode == 2) wy = wx;
    bx = $urandom_range(255 - wx);
    by = $urandom_range(255 - wy);
    if ($urandom_range(1)) begin
      sx = coord_t'(bx); ex = coord_t'(bx + wx);
    end else begin
      sx = coord_t'(bx + wx); ex = coord_t'(bx);
    end
    if ($urandom_range(1)) begin
      sy = coord_t'(by); ey = coord_t'(by + wy);
    end else begin
      sy = coord_t'(by + wy); ey = coord_t'(by);
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_advance();
    send_item(ACT_START, 8'd0, 8'd0, 8'd0, 8'd0);
    send_item(ACT_START, 8'd5, 8'd0, 8'd5, 8'd255);
    send_item(ACT_START, 8'd200, 8'd255, 8'd200, 8'd3);
    send_item(ACT_START, 8'd255, 8'd7, 8'd0, 8'd7);
    send_item(ACT_START, 8'd0, 8'd9, 8'd255, 8'd9);
    run_line(8'd0, 8'd0, 8'd3, 8'd3);
    send_item(ACT_START, 8'd10, 8'd10, 8'd20, 8'd14);
    send_advance();
    send_advance();
    run_line(8'd40, 8'd50, 8'd38, 8'd55);
    wait_drained();
  endtask

  task automatic test_coord_wrap();
    set_idling(0, 0);
    run_line(8'd1, 8'd0, 8'd0, 8'd10);
    run_line(8'd0, 8'd254, 8'd20, 8'd255);
    wait_drained();
  endtask

  task automatic test_long_lines();
    set_idling(0, 0);
    run_line(8'd0, 8'd255, 8'd255, 8'd0);
    run_line(8'd3, 8'd0, 8'd0, 8'd255);
    wait_drained();
  endtask

  task automatic test_random_lines(input int n_items, input int s_pct, input int r_pct);
    int sent, abort_at, k;
    logic act;
    coord_t sx, sy, ex, ey;
    set_idling(s_pct, r_pct);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        act = 1'($urandom_range(1));
        if (act == ACT_START || ln_active) sent++;
        send_item(act, any_coord(), any_coord(), any_coord(), any_coord());
      end else begin
        pick_line(sx, sy, ex, ey);
        send_item(ACT_START, sx, sy, ex, ey);
        sent++;
        abort_at = ($urandom_range(9) == 0) ? $urandom_range(6) : 1024;
        k = 0;
        while (ln_active && k < abort_at) begin
          send_advance();
          k++;
          sent++;
        end
        if ($urandom_range(9) == 0) send_advance();
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_line(8'd0, 8'd0, 8'd40, 8'd17);
    send_item(ACT_START, 8'd77, 8'd1, 8'd77, 8'd30);
    run_line(8'd90, 8'd90, 8'd80, 8'd120);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_coord_wrap();
    test_long_lines();
    test_random_lines(80, 0, 0);
    test_random_lines(80, 47, 0);
    test_random_lines(80, 0, 47);
    test_random_lines(80, 14, 14);
    test_backpressure();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
